// ===== sv/swk_pkg.sv =====
// Shared types and constants for the swerve wheel kinematics block.
// Holds the wheel layout, CORDIC arctangent table, datapath widths and
// the sequencer state types. No dependencies.
`default_nettype none

package swk_pkg;

    // Wheel layout
    localparam int NUM_WHEELS_DEF = 6;
    localparam int TABLE_WHEELS   = 6;
    localparam int WHEEL_W        = 3;

    // Wheel positions in mm, table order
    localparam logic signed [15:0] WHEEL_X [TABLE_WHEELS] = '{
        16'sd300, 16'sd0, -16'sd300, 16'sd300, 16'sd0, -16'sd300
    };
    localparam logic signed [15:0] WHEEL_Y [TABLE_WHEELS] = '{
        16'sd200, 16'sd200, 16'sd200, -16'sd200, -16'sd200, -16'sd200
    };

    // Datapath widths
    localparam int IN_W   = 16;   // command fields
    localparam int DIST_W = 17;   // wheel offset from pivot
    localparam int VEL_W  = 32;   // wheel velocity in 1/1024 mm/s
    localparam int PROD_W = 64;   // shared multiplier result
    localparam int SQR_W  = 62;   // one squared component
    localparam int RAD_W  = 64;   // square root working width
    localparam int COR_W  = 46;   // CORDIC x/y
    localparam int ACC_W  = 24;   // angle accumulator, 1/25600 degree
    localparam int ANG_W  = 25;   // final angle sum before scaling

    // Square root: one result bit per step
    localparam int SQ_STEPS = 32;
    localparam int SQ_CNT_W = 5;

    // Speed rounding: 1/1024 mm/s to mm/s
    localparam int SPD_SHIFT = 10;

    // Normalisation thresholds (powers of two) and coarse shift
    localparam int NORM_HI     = 40;
    localparam int NORM_LO     = 32;
    localparam int NORM_COARSE = 8;

    // CORDIC arctangent table, atan(2^-i) in 1/25600 degree
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 4;
    localparam int ATAN_W       = 21;
    localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        21'd1152000, 21'd680065, 21'd359328, 21'd182400,
        21'd91554,   21'd45822,  21'd22916,  21'd11459,
        21'd5730,    21'd2865,   21'd1432,   21'd716,
        21'd358,     21'd179,    21'd90,     21'd45
    };

    // Angles in hundredths of a degree
    localparam logic signed [IN_W-1:0] ANG_HALF = 16'sd18000;
    localparam logic signed [IN_W-1:0] ANG_QTR  = 16'sd9000;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_DY,
        ST_MUL_DX,
        ST_MUL_SQX,
        ST_MUL_SQY,
        ST_LOAD,
        ST_ITER,
        ST_FIN,
        ST_OUT
    } t_state;

    // CORDIC phase
    typedef enum logic [1:0] {
        COR_NORM,
        COR_ROT,
        COR_DONE
    } t_cor_phase;

endpackage

`default_nettype wire

// ===== sv/swerve_wheel_kinematics_top.sv =====
// Swerve wheel kinematics: body motion command in, one request per wheel out.
// Depends on swk_pkg for the wheel layout, arctangent table and state types.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) takes one body command: linear
//   velocity x/y, yaw rate and pivot point. The output channel
//   (o_out_valid / i_out_ready) then gives one request per wheel in table
//   order, the final one flagged by o_last_wheel.
//   Per wheel one signed multiplier forms yaw*dy, yaw*dx and the two
//   squares in turn, and a load state loads the units; then a
//   bit-per-cycle square root (32 steps) runs alongside a CORDIC unit
//   (normalise, then 16 rotations), then a rounding state registers the
//   wheel result.
//   One command is worked on at a time: o_in_ready is high only while
//   idle. While the receiver stalls, the current wheel result is held
//   unchanged and work stops until it is taken.
//   Reset (synchronous, active low) returns the sequencer to idle, drops
//   o_out_valid and clears the wheel counter and the unit control state.
`default_nettype none

module swerve_wheel_kinematics_top #(
    parameter int NUM_WHEELS = swk_pkg::NUM_WHEELS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // command channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic signed [swk_pkg::IN_W-1:0]   i_body_vel_x,
    input  wire logic signed [swk_pkg::IN_W-1:0]   i_body_vel_y,
    input  wire logic signed [swk_pkg::IN_W-1:0]   i_yaw_rate,
    input  wire logic signed [swk_pkg::IN_W-1:0]   i_pivot_x,
    input  wire logic signed [swk_pkg::IN_W-1:0]   i_pivot_y,
    // wheel result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [swk_pkg::WHEEL_W-1:0]            o_wheel_index,
    output logic signed [swk_pkg::IN_W-1:0]        o_steer_angle,
    output logic [swk_pkg::IN_W-1:0]               o_wheel_speed,
    output logic                                   o_speed_saturated,
    output logic                                   o_last_wheel
);
    import swk_pkg::*;

    // Wheels actually served, held to the size of the layout table
    localparam int ACTIVE = (NUM_WHEELS < 1) ? 1 :
                            (NUM_WHEELS > TABLE_WHEELS) ? TABLE_WHEELS : NUM_WHEELS;
    localparam logic [WHEEL_W-1:0] LAST_IDX = WHEEL_W'(ACTIVE - 1);

    localparam logic [RAD_W-1:0] SQ_TOP = RAD_W'(1) << (RAD_W - 2);
    localparam logic [SQ_CNT_W-1:0] SQ_LAST = SQ_CNT_W'(SQ_STEPS - 1);
    localparam logic [STEP_W-1:0] ROT_LAST = STEP_W'(CORDIC_STEPS - 1);
    localparam logic signed [COR_W-1:0] NORM_BIG = $signed(COR_W'(1) << NORM_HI);
    localparam logic signed [COR_W-1:0] NORM_SML = $signed(COR_W'(1) << NORM_LO);
    localparam logic signed [ANG_W-1:0] ANG_RND = $signed(ANG_W'(128));
    localparam logic [VEL_W:0] SPD_RND = (VEL_W+1)'(1) << (SPD_SHIFT - 1);

    // Sequencer
    t_state r_state, n_state;

    // Latched command
    logic signed [IN_W-1:0] r_bvx, r_bvy, r_yaw, r_pvx, r_pvy;
    logic [WHEEL_W-1:0]     r_wheel;

    // Shared multiplier
    logic signed [VEL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] r_prod;

    // Wheel velocity and squared x component
    logic signed [VEL_W-1:0] r_vx, r_vy;
    logic [SQR_W-1:0]        r_sq;

    // Square root unit
    logic [RAD_W-1:0]    r_rad, r_root, r_bit;
    logic [SQ_CNT_W-1:0] r_sq_cnt;
    logic                r_sq_done;

    // CORDIC unit
    t_cor_phase              r_cphase;
    logic signed [COR_W-1:0] r_cx, r_cy;
    logic signed [ACC_W-1:0] r_acc;
    logic [STEP_W-1:0]       r_ci;
    logic signed [IN_W-1:0]  r_base;

    // Result registers
    logic signed [IN_W-1:0] r_out_ang;
    logic [IN_W-1:0]        r_out_spd;
    logic                   r_out_sat;

    // Wheel offset from the pivot
    logic signed [DIST_W-1:0] dx, dy;
    assign dx = {WHEEL_X[r_wheel][IN_W-1], WHEEL_X[r_wheel]} - {r_pvx[IN_W-1], r_pvx};
    assign dy = {WHEEL_Y[r_wheel][IN_W-1], WHEEL_Y[r_wheel]} - {r_pvy[IN_W-1], r_pvy};

    // Body velocity scaled to 1/1024 mm/s
    logic signed [VEL_W-1:0] bvx_sc, bvy_sc;
    assign bvx_sc = {{(VEL_W-IN_W-SPD_SHIFT){r_bvx[IN_W-1]}}, r_bvx, {SPD_SHIFT{1'b0}}};
    assign bvy_sc = {{(VEL_W-IN_W-SPD_SHIFT){r_bvy[IN_W-1]}}, r_bvy, {SPD_SHIFT{1'b0}}};

    // Component magnitudes (always below 2^31)
    logic [VEL_W-1:0] vx_mag, vy_mag;
    assign vx_mag = r_vx[VEL_W-1] ? VEL_W'(-r_vx) : VEL_W'(r_vx);
    assign vy_mag = r_vy[VEL_W-1] ? VEL_W'(-r_vy) : VEL_W'(r_vy);

    // Multiplier operand select
    always_comb begin
        case (r_state)
            ST_MUL_DY: begin
                mul_a = VEL_W'(r_yaw);
                mul_b = VEL_W'(dy);
            end
            ST_MUL_DX: begin
                mul_a = VEL_W'(r_yaw);
                mul_b = VEL_W'(dx);
            end
            ST_MUL_SQX: begin
                mul_a = $signed({1'b0, vx_mag[VEL_W-2:0]});
                mul_b = $signed({1'b0, vx_mag[VEL_W-2:0]});
            end
            ST_MUL_SQY: begin
                mul_a = $signed({1'b0, vy_mag[VEL_W-2:0]});
                mul_b = $signed({1'b0, vy_mag[VEL_W-2:0]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Square root step
    logic [RAD_W-1:0] sq_trial;
    logic             sq_take;
    assign sq_trial = r_root + r_bit;
    assign sq_take  = (r_rad >= sq_trial);

    // CORDIC normalisation tests
    logic cor_big, cor_small;
    assign cor_big   = (r_cx >= NORM_BIG) || (r_cy >= NORM_BIG) || (r_cy <= -NORM_BIG);
    assign cor_small = (r_cx < NORM_SML) && (r_cy < NORM_SML) && (r_cy > -NORM_SML);

    // CORDIC rotation step
    logic signed [COR_W-1:0] cor_xs, cor_ys;
    logic signed [ACC_W-1:0] cor_atan;
    assign cor_xs   = r_cx >>> r_ci;
    assign cor_ys   = r_cy >>> r_ci;
    assign cor_atan = $signed({{(ACC_W-ATAN_W){1'b0}}, ATAN_TAB[r_ci]});

    // Speed rounding and saturation
    logic [VEL_W:0]           spd_round;
    logic [VEL_W-SPD_SHIFT:0] spd_q;
    logic                     spd_sat;
    assign spd_round = {1'b0, r_root[VEL_W-1:0]} + SPD_RND;
    assign spd_q     = spd_round[VEL_W:SPD_SHIFT];
    assign spd_sat   = |spd_q[VEL_W-SPD_SHIFT:IN_W];

    // Angle: base plus accumulator, rounded to hundredths and clamped
    logic signed [ANG_W-1:0] ang_sum, ang_div;
    logic signed [IN_W-1:0]  ang_fin;
    assign ang_sum = $signed({r_base[IN_W-1], r_base, 8'h00})
                   + $signed({r_acc[ACC_W-1], r_acc}) + ANG_RND;
    assign ang_div = ang_sum >>> 8;
    always_comb begin
        if (ang_div > $signed(ANG_W'(ANG_HALF))) begin
            ang_fin = ANG_HALF;
        end else if (ang_div < -$signed(ANG_W'(ANG_HALF))) begin
            ang_fin = -ANG_HALF;
        end else begin
            ang_fin = ang_div[IN_W-1:0];
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshake outputs
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) n_state = ST_MUL_DY;
            end
            ST_MUL_DY:  n_state = ST_MUL_DX;
            ST_MUL_DX:  n_state = ST_MUL_SQX;
            ST_MUL_SQX: n_state = ST_MUL_SQY;
            ST_MUL_SQY: n_state = ST_LOAD;
            ST_LOAD:    n_state = ST_ITER;
            ST_ITER: begin
                if (r_sq_done && (r_cphase == COR_DONE)) n_state = ST_FIN;
            end
            ST_FIN:     n_state = ST_OUT;
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = (r_wheel == LAST_IDX) ? ST_IDLE : ST_MUL_DY;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Wheel counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel <= '0;
        end else if (r_state == ST_IDLE) begin
            r_wheel <= '0;
        end else if ((r_state == ST_OUT) && i_out_ready) begin
            r_wheel <= r_wheel + WHEEL_W'(1);
        end
    end

    // Command latch and shared multiplier
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_in_valid) begin
            r_bvx <= i_body_vel_x;
            r_bvy <= i_body_vel_y;
            r_yaw <= i_yaw_rate;
            r_pvx <= i_pivot_x;
            r_pvy <= i_pivot_y;
        end
        r_prod <= mul_a * mul_b;
    end

    // Velocity components and squared x component
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_MUL_DX:  r_vx <= bvx_sc - r_prod[VEL_W-1:0];
            ST_MUL_SQX: r_vy <= bvy_sc + r_prod[VEL_W-1:0];
            ST_MUL_SQY: r_sq <= r_prod[SQR_W-1:0];
            default: ;
        endcase
    end

    // Square root unit: one result bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_done <= 1'b0;
            r_sq_cnt  <= '0;
        end else if (r_state == ST_LOAD) begin
            r_rad     <= RAD_W'(r_sq) + RAD_W'(r_prod[SQR_W-1:0]);
            r_root    <= '0;
            r_bit     <= SQ_TOP;
            r_sq_cnt  <= '0;
            r_sq_done <= 1'b0;
        end else if ((r_state == ST_ITER) && !r_sq_done) begin
            if (sq_take) begin
                r_rad  <= r_rad - sq_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit     <= r_bit >> 2;
            r_sq_cnt  <= r_sq_cnt + SQ_CNT_W'(1);
            r_sq_done <= (r_sq_cnt == SQ_LAST);
        end
    end

    // CORDIC unit: axis cases, half-plane fold, normalise, rotate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cphase <= COR_DONE;
            r_ci     <= '0;
        end else if (r_state == ST_LOAD) begin
            r_acc <= '0;
            r_ci  <= '0;
            r_cx  <= COR_W'(r_vx);
            r_cy  <= COR_W'(r_vy);
            if ((r_vx == '0) && (r_vy == '0)) begin
                r_base   <= '0;
                r_cphase <= COR_DONE;
            end else if (r_vy == '0) begin
                r_base   <= r_vx[VEL_W-1] ? ANG_HALF : '0;
                r_cphase <= COR_DONE;
            end else if (r_vx == '0) begin
                r_base   <= r_vy[VEL_W-1] ? -ANG_QTR : ANG_QTR;
                r_cphase <= COR_DONE;
            end else if (r_vx[VEL_W-1]) begin
                // left half-plane: rotate by half a turn
                r_base   <= r_vy[VEL_W-1] ? -ANG_HALF : ANG_HALF;
                r_cx     <= -COR_W'(r_vx);
                r_cy     <= -COR_W'(r_vy);
                r_cphase <= COR_NORM;
            end else begin
                r_base   <= '0;
                r_cphase <= COR_NORM;
            end
        end else if (r_state == ST_ITER) begin
            case (r_cphase)
                COR_NORM: begin
                    if (cor_big) begin
                        r_cphase <= COR_ROT;
                    end else if (cor_small) begin
                        r_cx <= r_cx <<< NORM_COARSE;
                        r_cy <= r_cy <<< NORM_COARSE;
                    end else begin
                        r_cx <= r_cx <<< 1;
                        r_cy <= r_cy <<< 1;
                    end
                end
                COR_ROT: begin
                    if (r_cy > 0) begin
                        r_cx  <= r_cx + cor_ys;
                        r_cy  <= r_cy - cor_xs;
                        r_acc <= r_acc + cor_atan;
                    end else begin
                        r_cx  <= r_cx - cor_ys;
                        r_cy  <= r_cy + cor_xs;
                        r_acc <= r_acc - cor_atan;
                    end
                    r_ci <= r_ci + STEP_W'(1);
                    if (r_ci == ROT_LAST) r_cphase <= COR_DONE;
                end
                default: ;
            endcase
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN) begin
            r_out_ang <= ang_fin;
            r_out_spd <= spd_sat ? {IN_W{1'b1}} : spd_q[IN_W-1:0];
            r_out_sat <= spd_sat;
        end
    end

    assign o_wheel_index     = r_wheel;
    assign o_steer_angle     = r_out_ang;
    assign o_wheel_speed     = r_out_spd;
    assign o_speed_saturated = r_out_sat;
    assign o_last_wheel      = (r_wheel == LAST_IDX);

    // Checks
    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("command taken while a wheel result is pending");

    a_wheel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_wheel_index <= LAST_IDX))
        else $error("wheel index beyond active wheel count");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_steer_angle <= ANG_HALF) && (o_steer_angle >= -ANG_HALF)))
        else $error("steer angle out of range");

    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_speed_saturated) |-> (o_wheel_speed == {IN_W{1'b1}}))
        else $error("saturated speed not clamped");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_wheel) |=> o_in_ready)
        else $error("no return to idle after last wheel");

    a_iter_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> (r_sq_done && (r_cphase == COR_DONE)))
        else $error("rounding started before both units finished");

endmodule

`default_nettype wire

// ===== tb/sv/tb_swerve_wheel_kinematics_top.sv =====
// Self-checking testbench for swerve_wheel_kinematics_top: directed and random body
// commands, random idling on both channels, one long output stall, per-wheel checking.
// Depends on swk_pkg (port widths) and the RTL top level; no files are read.
module tb_swerve_wheel_kinematics_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned t_u64;

    typedef struct {
        logic signed [swk_pkg::IN_W-1:0] vel_x;
        logic signed [swk_pkg::IN_W-1:0] vel_y;
        logic signed [swk_pkg::IN_W-1:0] yaw;
        logic signed [swk_pkg::IN_W-1:0] piv_x;
        logic signed [swk_pkg::IN_W-1:0] piv_y;
    } t_body_cmd;

    typedef struct {
        logic [swk_pkg::WHEEL_W-1:0]     index;
        logic signed [swk_pkg::IN_W-1:0] angle;
        logic [swk_pkg::IN_W-1:0]        speed;
        logic                            sat;
        logic                            last;
    } t_wheel_req;

    // Wheel layout in mm, table order
    localparam int WHEEL_COUNT = 6;
    localparam longint POS_X [WHEEL_COUNT] = '{300, 0, -300, 300, 0, -300};
    localparam longint POS_Y [WHEEL_COUNT] = '{200, 200, 200, -200, -200, -200};

    // atan(2^-i) in 1/25600 degree
    localparam int ROT_STEPS = 16;
    localparam longint ARCTAN_TAB [ROT_STEPS] = '{
        1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
        5730, 2865, 1432, 716, 358, 179, 90, 45
    };

    localparam longint HALF_TURN    = 18000;
    localparam longint QUARTER_TURN = 9000;
    localparam longint NORM_LIM     = longint'(1) << 40;
    localparam t_u64   SPEED_MAX    = 65535;

    localparam int MAX_GAP        = 16;
    localparam int HOLD_OFF_LEN   = 600;
    localparam int DRAIN_CYCLES   = 300;
    localparam int RANDOM_CMDS    = 150;
    localparam int CYCLE_LIMIT    = 400000;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic signed [swk_pkg::IN_W-1:0] i_body_vel_x;
    logic signed [swk_pkg::IN_W-1:0] i_body_vel_y;
    logic signed [swk_pkg::IN_W-1:0] i_yaw_rate;
    logic signed [swk_pkg::IN_W-1:0] i_pivot_x;
    logic signed [swk_pkg::IN_W-1:0] i_pivot_y;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [swk_pkg::WHEEL_W-1:0]     o_wheel_index;
    logic signed [swk_pkg::IN_W-1:0] o_steer_angle;
    logic [swk_pkg::IN_W-1:0]        o_wheel_speed;
    logic                            o_speed_saturated;
    logic                            o_last_wheel;

    t_wheel_req wheel_req_q[$];
    int  max_gap;
    bit  hold_off_req;
    int  mismatch_count;
    int  commands_sent;
    int  wheels_checked;
    int  sat_expected;
    int  cycle_count;

    swerve_wheel_kinematics_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_body_vel_x      (i_body_vel_x),
        .i_body_vel_y      (i_body_vel_y),
        .i_yaw_rate        (i_yaw_rate),
        .i_pivot_x         (i_pivot_x),
        .i_pivot_y         (i_pivot_y),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_wheel_index     (o_wheel_index),
        .o_steer_angle     (o_steer_angle),
        .o_wheel_speed     (o_wheel_speed),
        .o_speed_saturated (o_speed_saturated),
        .o_last_wheel      (o_last_wheel)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d wheel requests outstanding",
                 cycle_count, wheel_req_q.size());
        $display("swerve_wheel_kinematics_top regression: fail");
        $finish;
    end

    task automatic report_error(input string msg);
        mismatch_count++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // Floor of the square root, one result bit per pass
    function automatic t_u64 isqrt_floor(input t_u64 s);
        t_u64 res;
        t_u64 probe;
        res   = 0;
        probe = t_u64'(1) << 62;
        while (probe > s) probe = probe >> 2;
        while (probe != 0) begin
            if (s >= res + probe) begin
                s   = s - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    // Heading in hundredths of a degree: axes exact, else normalise and rotate
    function automatic logic signed [15:0] heading_cdeg(input longint vx, input longint vy);
        longint x, y, xs, ys, acc, base, total;
        int i;
        x    = vx;
        y    = vy;
        base = 0;
        acc  = 0;
        if (x == 0 && y == 0) return 16'sd0;
        if (y == 0) return (x > 0) ? 16'sd0 : 16'(HALF_TURN);
        if (x == 0) return (y > 0) ? 16'(QUARTER_TURN) : 16'(-QUARTER_TURN);
        // left half plane: fold over and add or take off half a turn
        if (x < 0) begin
            base = (y >= 0) ? HALF_TURN : -HALF_TURN;
            x    = -x;
            y    = -y;
        end
        while (x < NORM_LIM && ((y < 0) ? -y : y) < NORM_LIM) begin
            x = x * 2;
            y = y * 2;
        end
        for (i = 0; i < ROT_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x   = x + ys;
                y   = y - xs;
                acc = acc + ARCTAN_TAB[i];
            end else begin
                x   = x - ys;
                y   = y + xs;
                acc = acc - ARCTAN_TAB[i];
            end
        end
        total = (base * 256 + acc + 128) >>> 8;
        if (total > HALF_TURN) total = HALF_TURN;
        if (total < -HALF_TURN) total = -HALF_TURN;
        return 16'(total);
    endfunction

    // Expected per-wheel requests for one command, queued in table order
    task automatic predict_wheel_requests(input t_body_cmd c);
        t_wheel_req r;
        longint dx, dy, vx, vy, ax, ay;
        t_u64 mag, spd;
        int w;
        for (w = 0; w < WHEEL_COUNT; w++) begin
            dx  = POS_X[w] - longint'(c.piv_x);
            dy  = POS_Y[w] - longint'(c.piv_y);
            vx  = longint'(c.vel_x) * 1024 - longint'(c.yaw) * dy;
            vy  = longint'(c.vel_y) * 1024 + longint'(c.yaw) * dx;
            ax  = (vx < 0) ? -vx : vx;
            ay  = (vy < 0) ? -vy : vy;
            mag = isqrt_floor(t_u64'(ax * ax + ay * ay));
            spd = (mag + 512) >> 10;
            r.index = 3'(w);
            r.sat   = (spd > SPEED_MAX);
            r.speed = r.sat ? 16'hFFFF : spd[15:0];
            r.angle = heading_cdeg(vx, vy);
            r.last  = (w == WHEEL_COUNT - 1);
            if (r.sat) sat_expected++;
            wheel_req_q.push_back(r);
        end
    endtask

    // Offer one command after a random gap; valid holds until taken
    task automatic send_command(input logic signed [15:0] vel_x, vel_y, yaw, piv_x, piv_y);
        t_body_cmd c;
        int gap;
        c.vel_x = vel_x;
        c.vel_y = vel_y;
        c.yaw   = yaw;
        c.piv_x = piv_x;
        c.piv_y = piv_y;
        gap = $urandom_range(0, max_gap);
        repeat (gap) @(negedge i_clk) i_in_valid <= 1'b0;
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_body_vel_x <= vel_x;
        i_body_vel_y <= vel_y;
        i_yaw_rate   <= yaw;
        i_pivot_x    <= piv_x;
        i_pivot_y    <= piv_y;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready === 1'b1));
        predict_wheel_requests(c);
        commands_sent++;
    endtask

    // Result side: random stall per request, or one long hold-off on demand
    initial begin : wheel_sink
        t_wheel_req exp_req;
        int stall;
        i_out_ready = 1'b0;
        forever begin
            if (hold_off_req) begin
                stall        = HOLD_OFF_LEN;
                hold_off_req = 1'b0;
            end else begin
                stall = $urandom_range(0, max_gap);
            end
            repeat (stall) @(negedge i_clk) i_out_ready <= 1'b0;
            @(negedge i_clk) i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_out_ready));
            if (wheel_req_q.size() == 0) begin
                report_error($sformatf("wheel request with nothing expected (wheel %0d)",
                                       o_wheel_index));
            end else begin
                exp_req = wheel_req_q.pop_front();
                wheels_checked++;
                if (o_wheel_index !== exp_req.index)
                    report_error($sformatf("wheel_index got %0d want %0d",
                                           o_wheel_index, exp_req.index));
                if (o_steer_angle !== exp_req.angle)
                    report_error($sformatf("wheel %0d steer_angle got %0d want %0d",
                                           exp_req.index, o_steer_angle, exp_req.angle));
                if (o_wheel_speed !== exp_req.speed)
                    report_error($sformatf("wheel %0d wheel_speed got %0d want %0d",
                                           exp_req.index, o_wheel_speed, exp_req.speed));
                if (o_speed_saturated !== exp_req.sat)
                    report_error($sformatf("wheel %0d speed_saturated got %b want %b",
                                           exp_req.index, o_speed_saturated, exp_req.sat));
                if (o_last_wheel !== exp_req.last)
                    report_error($sformatf("wheel %0d last_wheel got %b want %b",
                                           exp_req.index, o_last_wheel, exp_req.last));
            end
        end
    end

    function automatic logic signed [15:0] rand_span(input int lim);
        return 16'($signed($urandom_range(0, 2 * lim)) - lim);
    endfunction

    // All zero: every wheel a zero vector
    task automatic test_zero_command();
        send_command(0, 0, 0, 0, 0);
    endtask

    // Pure translation along each axis, both signs, and three of the diagonals
    task automatic test_axis_headings();
        send_command(100, 0, 0, 0, 0);
        send_command(-5, 0, 0, 1234, -77);
        send_command(0, 250, 0, 0, 0);
        send_command(0, -250, 0, -900, 900);
        send_command(1, -1, 0, 0, 0);
        send_command(-1, 1, 0, 0, 0);
        send_command(-1, -1, 0, 0, 0);
    endtask

    // Field extremes, saturating speeds and the negative x axis under rotation
    task automatic test_field_extremes();
        send_command(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
        send_command(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
        send_command(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF);
        send_command(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        send_command(16'sh8000, 0, 0, 0, 0);
        send_command(0, 0, 16'sh7FFF, 0, 0);
        send_command(-300, 0, 1024, 0, 200);
    endtask

    // Tiny vectors that need deep normalisation, and pivots on wheels
    task automatic test_small_vectors();
        send_command(0, 0, 1, 0, 0);
        send_command(0, 0, -1, 0, 0);
        send_command(0, 0, 16'sh8000, 300, 200);
        send_command(3, -2, 5, 0, -200);
    endtask

    // Long output stall while commands keep coming: input must back up
    task automatic test_output_backpressure();
        int n;
        max_gap      = 0;
        hold_off_req = 1'b1;
        for (n = 0; n < 4; n++)
            send_command(rand_span(3000), rand_span(3000), rand_span(3000),
                         rand_span(1000), rand_span(1000));
        max_gap = MAX_GAP;
    endtask

    // Random commands: full range, realistic, on-axis and pivot-on-wheel mixes
    task automatic test_random_commands();
        int n, kind, w;
        logic signed [15:0] vx, vy, yaw, px, py;
        for (n = 0; n < RANDOM_CMDS; n++) begin
            max_gap = (n >= 60 && n < 90) ? 0 : MAX_GAP;
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                vx  = 16'($urandom);
                vy  = 16'($urandom);
                yaw = 16'($urandom);
                px  = 16'($urandom);
                py  = 16'($urandom);
            end else if (kind < 65) begin
                vx  = rand_span(3000);
                vy  = rand_span(3000);
                yaw = rand_span(4000);
                px  = rand_span(1000);
                py  = rand_span(1000);
            end else if (kind < 80) begin
                // no rotation, one component zeroed: every wheel on an axis
                vx  = $urandom_range(0, 1) ? 16'($urandom) : 16'sd0;
                vy  = (vx == 0) ? 16'($urandom) : 16'sd0;
                yaw = 16'sd0;
                px  = 16'($urandom);
                py  = 16'($urandom);
            end else begin
                // pivot on a wheel, pure rotation or a small added translation
                w   = $urandom_range(0, WHEEL_COUNT - 1);
                px  = 16'(POS_X[w]);
                py  = 16'(POS_Y[w]);
                yaw = 16'($urandom);
                vx  = $urandom_range(0, 2) == 0 ? rand_span(500) : 16'sd0;
                vy  = $urandom_range(0, 2) == 0 ? rand_span(500) : 16'sd0;
            end
            send_command(vx, vy, yaw, px, py);
        end
        max_gap = MAX_GAP;
    endtask

    // Main sequence
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_body_vel_x   = '0;
        i_body_vel_y   = '0;
        i_yaw_rate     = '0;
        i_pivot_x      = '0;
        i_pivot_y      = '0;
        max_gap        = MAX_GAP;
        hold_off_req   = 1'b0;
        mismatch_count = 0;
        commands_sent  = 0;
        wheels_checked = 0;
        sat_expected   = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_zero_command();
        test_axis_headings();
        test_field_extremes();
        test_small_vectors();
        test_output_backpressure();
        test_random_commands();
        @(negedge i_clk) i_in_valid <= 1'b0;

        // drain, then give stray requests time to show
        while (wheel_req_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (wheel_req_q.size() != 0)
            report_error($sformatf("%0d wheel requests never arrived", wheel_req_q.size()));

        $display("%0d body commands driven, %0d wheel requests compared (%0d with saturated speed)",
                 commands_sent, wheels_checked, sat_expected);
        $display("included axis headings, zero vectors, field extremes and a %0d-cycle output stall",
                 HOLD_OFF_LEN);
        if (mismatch_count == 0) begin
            $display("swerve_wheel_kinematics_top regression: pass");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("swerve_wheel_kinematics_top regression: fail");
        end
        $finish;
    end

endmodule
